// ----- sv/c2i_pkg.sv -----
`timescale 1ns / 1ps

package c2i_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_HEIGHT    = 64;
    localparam int DEF_MAX_WIDTH     = 64;
    localparam int DEF_MAX_KERNEL    = 16;
    localparam int DEF_DILATION_ROWS = 1;
    localparam int DEF_DILATION_COLS = 1;

    // Field widths.
    localparam int DATA_W     = 32;
    localparam int PLANE_W    = 7;
    localparam int KERN_W     = 5;
    localparam int PAD_W      = 4;
    localparam int STEP_W     = 5;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;
    localparam int APB_DATA_W = 32;

    // Output grid counts stay below 256 since plane plus twice the padding is at most 157.
    localparam int OCNT_W = 8;
    // Unpadded position sum: kernel offset plus output offset times stride.
    localparam int POS_W  = 13;
    // Linear pixel address and plane size, row times width plus column.
    localparam int PROD_W = 14;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_WIDTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAD_ROWS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PAD_COLS     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STEP_ROWS    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STEP_COLS    = 3'd7;

    // Command codes.
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [PLANE_W-1:0] height;
        logic [PLANE_W-1:0] width;
        logic [KERN_W-1:0]  krows;
        logic [KERN_W-1:0]  kcols;
        logic [PAD_W-1:0]   prows;
        logic [PAD_W-1:0]   pcols;
        logic [STEP_W-1:0]  srows;
        logic [STEP_W-1:0]  scols;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS,
        ST_ADDR,
        ST_READ,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_en;
        logic pos_en;
        logic addr_en;
        logic rd_en;
        logic wr_en;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic div_busy;
    } ctrl_sts_t;

    // Signed add that saturates to the 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        logic signed [DATA_W-1:0] r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/c2i_ram.sv -----
`timescale 1ns / 1ps

module c2i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/c2i_div.sv -----
`timescale 1ns / 1ps

module c2i_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [c2i_pkg::OCNT_W-1:0]   num,
    input  logic [c2i_pkg::STEP_W-1:0]   den,
    input  logic                         empty,
    output logic [c2i_pkg::OCNT_W-1:0]   count,
    output logic                         busy
);

    import c2i_pkg::*;

    localparam int SW = $clog2(OCNT_W);

    logic              pend_reg;
    logic              run_reg;
    logic              empty_reg;
    logic [SW-1:0]     step_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] rem_next;
    logic [OCNT_W-1:0] quo_reg;
    logic [OCNT_W-1:0] quo_next;
    logic [OCNT_W-1:0] shift_reg;
    logic [OCNT_W-1:0] count_reg;
    logic [STEP_W:0]   trial;
    logic              fits;

    // One restoring division step: bring down the next numerator bit and try the subtract.
    always_comb
    begin
        trial    = {rem_reg, shift_reg[OCNT_W-1]};
        fits     = trial >= {1'b0, den};
        rem_next = fits ? STEP_W'(trial - {1'b0, den}) : STEP_W'(trial);
        quo_next = {quo_reg[OCNT_W-2:0], fits};
    end

    // Operands are loaded in the cycle after the write, once the registers hold the new values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            run_reg   <= 1'b0;
            empty_reg <= 1'b0;
            step_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            shift_reg <= '0;
            count_reg <= OCNT_W'(1);
        end
        else
        begin
            pend_reg <= start;
            if (pend_reg)
            begin
                shift_reg <= num;
                rem_reg   <= '0;
                quo_reg   <= '0;
                step_reg  <= '0;
                empty_reg <= empty;
                run_reg   <= 1'b1;
            end
            else if (run_reg)
            begin
                shift_reg <= {shift_reg[OCNT_W-2:0], 1'b0};
                rem_reg   <= rem_next;
                quo_reg   <= quo_next;
                step_reg  <= step_reg + 1'b1;
                if (step_reg == SW'(OCNT_W - 1))
                begin
                    run_reg   <= 1'b0;
                    count_reg <= empty_reg ? '0 : quo_next + 1'b1;
                end
            end
        end
    end

    assign count = count_reg;
    assign busy  = pend_reg | run_reg;

endmodule

// ----- sv/c2i_cfg.sv -----
`timescale 1ns / 1ps

module c2i_cfg #(
    parameter int MAX_HEIGHT = c2i_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = c2i_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = c2i_pkg::DEF_MAX_KERNEL
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [c2i_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [c2i_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [c2i_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output c2i_pkg::cfg_t                   cfg,
    output logic                            cfg_wr
);

    import c2i_pkg::*;

    logic [PLANE_W-1:0]   height_reg;
    logic [PLANE_W-1:0]   width_reg;
    logic [KERN_W-1:0]    krows_reg;
    logic [KERN_W-1:0]    kcols_reg;
    logic [PAD_W-1:0]     prows_reg;
    logic [PAD_W-1:0]     pcols_reg;
    logic [STEP_W-1:0]    srows_reg;
    logic [STEP_W-1:0]    scols_reg;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= PLANE_W'(1);
            width_reg  <= PLANE_W'(1);
            krows_reg  <= KERN_W'(1);
            kcols_reg  <= KERN_W'(1);
            prows_reg  <= '0;
            pcols_reg  <= '0;
            srows_reg  <= STEP_W'(1);
            scols_reg  <= STEP_W'(1);
        end
        else if (cfg_wr)
        begin
            case (idx)
                REG_PLANE_HEIGHT: height_reg <= pwdata[PLANE_W-1:0];
                REG_PLANE_WIDTH:  width_reg  <= pwdata[PLANE_W-1:0];
                REG_KERNEL_ROWS:  krows_reg  <= pwdata[KERN_W-1:0];
                REG_KERNEL_COLS:  kcols_reg  <= pwdata[KERN_W-1:0];
                REG_PAD_ROWS:     prows_reg  <= pwdata[PAD_W-1:0];
                REG_PAD_COLS:     pcols_reg  <= pwdata[PAD_W-1:0];
                REG_STEP_ROWS:    srows_reg  <= pwdata[STEP_W-1:0];
                REG_STEP_COLS:    scols_reg  <= pwdata[STEP_W-1:0];
                default:          height_reg <= height_reg;
            endcase
        end
    end

    // Read back the raw register values.
    always_comb
    begin
        case (idx)
            REG_PLANE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_PLANE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_KERNEL_ROWS:  prdata = APB_DATA_W'(krows_reg);
            REG_KERNEL_COLS:  prdata = APB_DATA_W'(kcols_reg);
            REG_PAD_ROWS:     prdata = APB_DATA_W'(prows_reg);
            REG_PAD_COLS:     prdata = APB_DATA_W'(pcols_reg);
            REG_STEP_ROWS:    prdata = APB_DATA_W'(srows_reg);
            REG_STEP_COLS:    prdata = APB_DATA_W'(scols_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp sizes into their supported ranges; a zero stride acts as one.
    always_comb
    begin
        cfg.height = (height_reg == '0) ? PLANE_W'(1) :
                     ((int'(height_reg) > MAX_HEIGHT) ? PLANE_W'(MAX_HEIGHT) : height_reg);
        cfg.width  = (width_reg == '0) ? PLANE_W'(1) :
                     ((int'(width_reg) > MAX_WIDTH) ? PLANE_W'(MAX_WIDTH) : width_reg);
        cfg.krows  = (krows_reg == '0) ? KERN_W'(1) :
                     ((int'(krows_reg) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : krows_reg);
        cfg.kcols  = (kcols_reg == '0) ? KERN_W'(1) :
                     ((int'(kcols_reg) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : kcols_reg);
        cfg.prows  = prows_reg;
        cfg.pcols  = pcols_reg;
        cfg.srows  = (srows_reg == '0) ? STEP_W'(1) : srows_reg;
        cfg.scols  = (scols_reg == '0) ? STEP_W'(1) : scols_reg;
    end

endmodule

// ----- sv/c2i_ctrl.sv -----
`timescale 1ns / 1ps

module c2i_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  c2i_pkg::ctrl_sts_t    sts,
    output logic                  busy,
    output c2i_pkg::ctrl_cmd_t    ccmd
);

    import c2i_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && !sts.div_busy)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:   state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        ccmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR: ccmd.clear_en = 1'b1;
            ST_IDLE:
            begin
                busy        = sts.div_busy;
                ccmd.accept = start & ~sts.div_busy;
            end
            ST_POS:   ccmd.pos_en  = 1'b1;
            ST_ADDR:  ccmd.addr_en = 1'b1;
            ST_READ:  ccmd.rd_en   = 1'b1;
            ST_WRITE: ccmd.wr_en   = 1'b1;
            default:  ccmd = '0;
        endcase
    end

endmodule

// ----- sv/c2i_dp.sv -----
`timescale 1ns / 1ps

module c2i_dp #(
    parameter int MAX_HEIGHT    = c2i_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH     = c2i_pkg::DEF_MAX_WIDTH,
    parameter int DILATION_ROWS = c2i_pkg::DEF_DILATION_ROWS,
    parameter int DILATION_COLS = c2i_pkg::DEF_DILATION_COLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  c2i_pkg::cfg_t                      cfg,
    input  logic                               cfg_wr,
    input  c2i_pkg::ctrl_cmd_t                 ccmd,
    output c2i_pkg::ctrl_sts_t                 sts,
    input  logic                               cmd,
    input  logic signed [c2i_pkg::DATA_W-1:0]  col_value,
    output logic signed [c2i_pkg::DATA_W-1:0]  pixel_value,
    output logic                               last_pixel,
    output logic                               out_valid
);

    import c2i_pkg::*;

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (AW > PROD_W) ? AW : PROD_W;

    // Latched command.
    logic                     cmd_reg;
    logic signed [DATA_W-1:0] value_reg;

    // Position counters.
    logic [KERN_W-1:0] kr_reg;
    logic [KERN_W-1:0] kc_reg;
    logic [OCNT_W-1:0] orow_reg;
    logic [OCNT_W-1:0] ocol_reg;
    logic [AW-1:0]     didx_reg;
    logic [AW-1:0]     clr_addr_reg;

    // Output grid size.
    logic [OCNT_W:0]   ext_r;
    logic [OCNT_W:0]   ext_c;
    logic [OCNT_W:0]   need_r;
    logic [OCNT_W:0]   need_c;
    logic [OCNT_W-1:0] num_r;
    logic [OCNT_W-1:0] num_c;
    logic              empty_r;
    logic              empty_c;
    logic [OCNT_W-1:0] oh;
    logic [OCNT_W-1:0] ow;
    logic              busy_r;
    logic              busy_c;
    logic              grid_empty;

    // Position stage.
    logic              bad;
    logic [KERN_W-1:0] cur_kr;
    logic [KERN_W-1:0] cur_kc;
    logic [OCNT_W-1:0] cur_orow;
    logic [OCNT_W-1:0] cur_ocol;
    logic [KERN_W-1:0] kr_n;
    logic [KERN_W-1:0] kc_n;
    logic [OCNT_W-1:0] orow_n;
    logic [OCNT_W-1:0] ocol_n;
    logic [OCNT_W:0]   ocol_inc;
    logic [OCNT_W:0]   orow_inc;
    logic [KERN_W:0]   kc_inc;
    logic [KERN_W:0]   kr_inc;
    logic [POS_W-1:0]  rsum;
    logic [POS_W-1:0]  csum;
    logic              row_hit;
    logic              col_hit;
    logic [PLANE_W-1:0] row_reg;
    logic [PLANE_W-1:0] col_reg;
    logic              pos_hit_reg;

    // Address stage.
    logic [PROD_W-1:0] total;
    logic [PROD_W-1:0] lin;
    logic [AW-1:0]     didx_eff;
    logic              drain_last;
    logic [AW-1:0]     addr_reg;
    logic              hit_reg;
    logic              last_reg;

    // Store access and result.
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] pixel_value_reg;
    logic                     last_pixel_reg;
    logic                     out_valid_reg;

    // Numerators of the output grid counts: plane + 2*pad - (dilation*(kernel-1) + 1).
    always_comb
    begin
        ext_r   = (OCNT_W+1)'(cfg.height) + ((OCNT_W+1)'(cfg.prows) << 1);
        ext_c   = (OCNT_W+1)'(cfg.width) + ((OCNT_W+1)'(cfg.pcols) << 1);
        need_r  = (OCNT_W+1)'(DILATION_ROWS * (int'(cfg.krows) - 1) + 1);
        need_c  = (OCNT_W+1)'(DILATION_COLS * (int'(cfg.kcols) - 1) + 1);
        empty_r = need_r > ext_r;
        empty_c = need_c > ext_c;
        num_r   = OCNT_W'(ext_r - need_r);
        num_c   = OCNT_W'(ext_c - need_c);
    end

    // Output grid counts are divided out after each register write.
    c2i_div u_div_rows (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr),
        .num   (num_r),
        .den   (cfg.srows),
        .empty (empty_r),
        .count (oh),
        .busy  (busy_r)
    );

    c2i_div u_div_cols (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr),
        .num   (num_c),
        .den   (cfg.scols),
        .empty (empty_c),
        .count (ow),
        .busy  (busy_c)
    );

    assign grid_empty = (oh == '0) || (ow == '0);

    // Current position, the pixel it lands on, and the next counter values.
    always_comb
    begin
        bad = (kr_reg >= cfg.krows) || (kc_reg >= cfg.kcols) ||
              (orow_reg >= oh) || (ocol_reg >= ow);
        cur_kr   = bad ? '0 : kr_reg;
        cur_kc   = bad ? '0 : kc_reg;
        cur_orow = bad ? '0 : orow_reg;
        cur_ocol = bad ? '0 : ocol_reg;

        rsum = POS_W'(cur_kr) * POS_W'(DILATION_ROWS) + POS_W'(cur_orow) * POS_W'(cfg.srows);
        csum = POS_W'(cur_kc) * POS_W'(DILATION_COLS) + POS_W'(cur_ocol) * POS_W'(cfg.scols);
        row_hit = (rsum >= POS_W'(cfg.prows)) &&
                  (rsum < POS_W'(cfg.prows) + POS_W'(cfg.height));
        col_hit = (csum >= POS_W'(cfg.pcols)) &&
                  (csum < POS_W'(cfg.pcols) + POS_W'(cfg.width));

        ocol_inc = (OCNT_W+1)'(cur_ocol) + 1'b1;
        orow_inc = (OCNT_W+1)'(cur_orow) + 1'b1;
        kc_inc   = (KERN_W+1)'(cur_kc) + 1'b1;
        kr_inc   = (KERN_W+1)'(cur_kr) + 1'b1;

        kr_n   = cur_kr;
        kc_n   = cur_kc;
        orow_n = cur_orow;
        ocol_n = OCNT_W'(ocol_inc);
        if (ocol_inc >= (OCNT_W+1)'(ow))
        begin
            ocol_n = '0;
            orow_n = OCNT_W'(orow_inc);
            if (orow_inc >= (OCNT_W+1)'(oh))
            begin
                orow_n = '0;
                kc_n   = KERN_W'(kc_inc);
                if (kc_inc >= (KERN_W+1)'(cfg.kcols))
                begin
                    kc_n = '0;
                    kr_n = (kr_inc >= (KERN_W+1)'(cfg.krows)) ? '0 : KERN_W'(kr_inc);
                end
            end
        end
    end

    // Drain index and linear address.
    always_comb
    begin
        total      = PROD_W'(cfg.height) * PROD_W'(cfg.width);
        lin        = PROD_W'(row_reg) * PROD_W'(cfg.width) + PROD_W'(col_reg);
        didx_eff   = (IW'(didx_reg) >= IW'(total)) ? '0 : didx_reg;
        drain_last = IW'(didx_eff) == IW'(total) - 1'b1;
    end

    // Counters, drain index and clearing address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg       <= '0;
            kc_reg       <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            didx_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (ccmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_wr)
            begin
                kr_reg   <= '0;
                kc_reg   <= '0;
                orow_reg <= '0;
                ocol_reg <= '0;
                didx_reg <= '0;
            end
            else
            begin
                if (ccmd.pos_en && cmd_reg == CMD_ACCUM && !grid_empty)
                begin
                    kr_reg   <= kr_n;
                    kc_reg   <= kc_n;
                    orow_reg <= orow_n;
                    ocol_reg <= ocol_n;
                end
                if (ccmd.addr_en && cmd_reg == CMD_DRAIN)
                begin
                    didx_reg <= drain_last ? '0 : didx_eff + 1'b1;
                end
            end
        end
    end

    // Command latch and pipeline payload.
    always_ff @(posedge clk)
    begin
        if (ccmd.accept)
        begin
            cmd_reg   <= cmd;
            value_reg <= col_value;
        end
        if (ccmd.pos_en)
        begin
            row_reg     <= PLANE_W'(rsum - POS_W'(cfg.prows));
            col_reg     <= PLANE_W'(csum - POS_W'(cfg.pcols));
            pos_hit_reg <= row_hit && col_hit && !grid_empty;
        end
        if (ccmd.addr_en)
        begin
            addr_reg <= (cmd_reg == CMD_DRAIN) ? didx_eff : AW'(lin);
            hit_reg  <= (cmd_reg == CMD_DRAIN) || pos_hit_reg;
            last_reg <= drain_last;
        end
        if (ccmd.wr_en && cmd_reg == CMD_DRAIN)
        begin
            pixel_value_reg <= rd_data;
            last_pixel_reg  <= last_reg;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ccmd.wr_en && (cmd_reg == CMD_DRAIN);
        end
    end

    // Store write: zero during the clearing pass and on a drain, else the saturated sum.
    always_comb
    begin
        ram_we    = ccmd.clear_en | (ccmd.wr_en & hit_reg);
        ram_waddr = ccmd.clear_en ? clr_addr_reg : addr_reg;
        if (ccmd.clear_en || cmd_reg == CMD_DRAIN)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata = sat_add(rd_data, value_reg);
        end
    end

    c2i_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ccmd.rd_en),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign sts.clear_last = clr_addr_reg == AW'(DEPTH - 1);
    assign sts.div_busy   = busy_r | busy_c;

    assign pixel_value = pixel_value_reg;
    assign last_pixel  = last_pixel_reg;
    assign out_valid   = out_valid_reg;

endmodule

// ----- sv/col2im_scatter_accumulate_top.sv -----
`timescale 1ns / 1ps

// col2im scatter-accumulate for one channel plane. A command is taken when start is high
// and busy is low. An accumulate command (cmd 0) adds col_value, with signed saturation,
// into the plane pixel that the current kernel and output position maps to, and gives no
// result; a drain command (cmd 1) reads the next pixel in row-major order, clears it, and
// presents it on pixel_value for exactly one cycle with out_valid high and last_pixel set on
// the final pixel. The receiver cannot stall, so it must take every result in that cycle.
// Each command passes through the position, address, store read and store write states one
// after another, through the single store port pair, before the next command is accepted.
// A drain result is registered in the store write state. After reset the store is cleared
// one pixel per cycle, all MAX_HEIGHT*MAX_WIDTH pixels (4096 by default), with busy high.
// Every register write restarts the position counters and divides out the output grid
// size, holding busy high until both divisions finish; the plane contents are kept.

module col2im_scatter_accumulate_top #(
    parameter int MAX_HEIGHT    = c2i_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH     = c2i_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL    = c2i_pkg::DEF_MAX_KERNEL,
    parameter int DILATION_ROWS = c2i_pkg::DEF_DILATION_ROWS,
    parameter int DILATION_COLS = c2i_pkg::DEF_DILATION_COLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic signed [c2i_pkg::DATA_W-1:0]  col_value,
    output logic signed [c2i_pkg::DATA_W-1:0]  pixel_value,
    output logic                               last_pixel,
    output logic                               out_valid,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [c2i_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [c2i_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [c2i_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    import c2i_pkg::*;

    cfg_t      cfg;
    logic      cfg_wr;
    ctrl_cmd_t ccmd;
    ctrl_sts_t sts;

    // Configuration registers.
    c2i_cfg #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    // Sequencer.
    c2i_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .ccmd  (ccmd)
    );

    // Counters, address arithmetic and the plane store.
    c2i_dp #(
        .MAX_HEIGHT    (MAX_HEIGHT),
        .MAX_WIDTH     (MAX_WIDTH),
        .DILATION_ROWS (DILATION_ROWS),
        .DILATION_COLS (DILATION_COLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_wr      (cfg_wr),
        .ccmd        (ccmd),
        .sts         (sts),
        .cmd         (cmd),
        .col_value   (col_value),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid)
    );

endmodule
